// File: design/two_sided_cusum_detector_unit_defines.svh
// Assertion macros for the CUSUM detector checker
`ifndef TWO_SIDED_CUSUM_DETECTOR_UNIT_DEFINES_SVH
`define TWO_SIDED_CUSUM_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TSCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tscd_pkg.sv
package tscd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MeanW   = 16;
  localparam int unsigned HalfW   = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ThrW    = 47;
  localparam int unsigned SumW    = 48;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned DiffW   = 18;
  localparam int unsigned IncW    = DiffW + GainW + 1;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = ThrW;

  localparam logic [CfgAddrW-1:0] RegRefMean   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegHalfMag   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegGain      = 2'd2;
  localparam logic [CfgAddrW-1:0] RegThreshold = 2'd3;

  localparam logic [GainW-1:0] GainReset = 16'd256;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic signed [IncW-1:0] up_inc;
    logic signed [IncW-1:0] dn_inc;
  } incr_t;

  typedef struct packed {
    logic [IdxW-1:0] change_index;
    logic [IdxW-1:0] alarm_index;
    logic            direction;
    logic            alarm;
  } result_t;

endpackage

// File: design/two_sided_cusum_detector_unit.sv
// Two-sided CUSUM change detector.
// Input stream: one signed 16-bit sample per transfer on s_axis_*.
// Output stream: one result per sample on m_axis_*: alarm flag, direction
// (0 up, 1 down), alarm index and estimated change index. Without an alarm
// the other fields are zero.
// Configuration: cfg_we_i/cfg_addr_i/cfg_wdata_i write reference mean,
// half magnitude, gain (Q8.8) and threshold; write only while idle.
// Path: an accepted sample is written into the queue, then popped by the
// back end into the result register that drives m_axis_*.
// Throughput: one sample per cycle while the output is not stalled. The front
// computes both scaled increments (one multiplier per side) into a 4-entry
// queue; the back does saturating accumulate, minimum tracking and the
// threshold compare for each sample that it pops.
// Reset: sums, minima, indices and sample count clear; registers take
// their reset values; no results pending.
// Stall: a stalled output holds its result; the queue absorbs up to four
// more samples, then s_axis_tready drops until the receiver resumes.
module two_sided_cusum_detector_unit
  import tscd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,  // [15:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata   // [0] alarm, [1] direction,
                                              // [17:2] alarm_index,
                                              // [33:18] change_index, rest 0
);

  logic [MeanW-1:0] ref_mean_q;
  logic [HalfW-1:0] half_mag_q;
  logic [GainW-1:0] gain_q;
  logic [ThrW-1:0]  thr_q;

  incr_t   front_incr, q_incr;
  logic    q_full, q_valid, q_pop, push;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mean_q <= '0;
      half_mag_q <= '0;
      gain_q     <= GainReset;
      thr_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegRefMean:   ref_mean_q <= cfg_wdata_i[MeanW-1:0];
        RegHalfMag:   half_mag_q <= cfg_wdata_i[HalfW-1:0];
        RegGain:      gain_q     <= cfg_wdata_i[GainW-1:0];
        RegThreshold: thr_q      <= cfg_wdata_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  tscd_front u_front (
    .sample_i   (s_axis_tdata[SampleW-1:0]),
    .ref_mean_i (ref_mean_q),
    .half_mag_i (half_mag_q),
    .gain_i     (gain_q),
    .incr_o     (front_incr)
  );

  tscd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_incr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_incr)
  );

  tscd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .in_valid_i  (q_valid),
    .incr_i      (q_incr),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .result_o    (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, res};

endmodule

// File: design/tscd_front.sv
module tscd_front
  import tscd_pkg::*;
(
  input  logic [SampleW-1:0] sample_i,
  input  logic [MeanW-1:0]   ref_mean_i,
  input  logic [HalfW-1:0]   half_mag_i,
  input  logic [GainW-1:0]   gain_i,
  output incr_t              incr_o
);

  logic signed [DiffW-1:0] s_ext;
  logic signed [DiffW-1:0] m_ext;
  logic signed [DiffW-1:0] h_ext;
  logic signed [DiffW-1:0] du;
  logic signed [DiffW-1:0] dd;
  logic signed [GainW:0]   g_ext;

  always_comb begin
    s_ext = $signed({{(DiffW-SampleW){sample_i[SampleW-1]}}, sample_i});
    m_ext = $signed({{(DiffW-MeanW){ref_mean_i[MeanW-1]}}, ref_mean_i});
    h_ext = $signed({{(DiffW-HalfW){1'b0}}, half_mag_i});
    g_ext = $signed({1'b0, gain_i});
    du = s_ext - m_ext - h_ext;
    dd = m_ext - s_ext - h_ext;
    incr_o.up_inc = IncW'(du) * IncW'(g_ext);
    incr_o.dn_inc = IncW'(dd) * IncW'(g_ext);
  end

endmodule

// File: design/tscd_fifo.sv
module tscd_fifo
  import tscd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  incr_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output incr_t rdata_o
);

  incr_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QDepth[QPtrW:0]);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/tscd_back.sv
module tscd_back
  import tscd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ThrW-1:0] threshold_i,
  input  logic            in_valid_i,
  input  incr_t           incr_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output result_t         result_o,
  input  logic            out_ready_i
);

  logic signed [SumW-1:0] up_sum_q, up_sum_d, up_min_q, up_min_d;
  logic signed [SumW-1:0] dn_sum_q, dn_sum_d, dn_min_q, dn_min_d;
  logic [IdxW-1:0]        up_idx_q, up_idx_d, dn_idx_q, dn_idx_d;
  logic [IdxW-1:0]        cnt_q, cnt_d, cnt_next;
  logic                   out_valid_q, out_valid_d;
  result_t                res_q, res_d;
  logic [SumW:0]          up_raw, dn_raw, up_gap, dn_gap;
  logic                   up_hit, dn_hit;

  assign pop_o       = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    cnt_next = cnt_q + 1'b1;
    up_raw = {up_sum_q[SumW-1], up_sum_q}
           + {{(SumW+1-IncW){incr_i.up_inc[IncW-1]}}, incr_i.up_inc};
    dn_raw = {dn_sum_q[SumW-1], dn_sum_q}
           + {{(SumW+1-IncW){incr_i.dn_inc[IncW-1]}}, incr_i.dn_inc};

    if (up_raw[SumW] != up_raw[SumW-1]) begin
      up_sum_d = up_raw[SumW] ? SumMin : SumMax;
    end else begin
      up_sum_d = up_raw[SumW-1:0];
    end
    if (dn_raw[SumW] != dn_raw[SumW-1]) begin
      dn_sum_d = dn_raw[SumW] ? SumMin : SumMax;
    end else begin
      dn_sum_d = dn_raw[SumW-1:0];
    end

    up_min_d = up_min_q;
    up_idx_d = up_idx_q;
    if (up_sum_d < up_min_q) begin
      up_min_d = up_sum_d;
      up_idx_d = cnt_next;
    end
    dn_min_d = dn_min_q;
    dn_idx_d = dn_idx_q;
    if (dn_sum_d < dn_min_q) begin
      dn_min_d = dn_sum_d;
      dn_idx_d = cnt_next;
    end

    // minimum never exceeds the sum, so the gap is non-negative
    up_gap = {up_sum_d[SumW-1], up_sum_d} - {up_min_d[SumW-1], up_min_d};
    dn_gap = {dn_sum_d[SumW-1], dn_sum_d} - {dn_min_d[SumW-1], dn_min_d};
    up_hit = up_gap > {2'b00, threshold_i};
    dn_hit = dn_gap > {2'b00, threshold_i};

    res_d = '0;
    cnt_d = cnt_next;
    if (up_hit || dn_hit) begin
      res_d.alarm        = 1'b1;
      res_d.direction    = !up_hit;
      res_d.alarm_index  = cnt_q;
      res_d.change_index = up_hit ? up_idx_d : dn_idx_d;
      up_sum_d = '0;
      up_min_d = '0;
      up_idx_d = '0;
      dn_sum_d = '0;
      dn_min_d = '0;
      dn_idx_d = '0;
      cnt_d    = '0;
    end

    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_sum_q    <= '0;
      up_min_q    <= '0;
      up_idx_q    <= '0;
      dn_sum_q    <= '0;
      dn_min_q    <= '0;
      dn_idx_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        up_sum_q <= up_sum_d;
        up_min_q <= up_min_d;
        up_idx_q <= up_idx_d;
        dn_sum_q <= dn_sum_d;
        dn_min_q <= dn_min_d;
        dn_idx_q <= dn_idx_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: design/tscd_checker.sv
`include "two_sided_cusum_detector_unit_defines.svh"

module tscd_checker
  import tscd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  `TSCD_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
                    s_axis_tvalid && $stable(s_axis_tdata), "waiting sample changed")
  `TSCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `TSCD_ASSERT_NOW(a_quiet_fields, m_axis_tvalid && !m_axis_tdata[0],
                   m_axis_tdata[33:1] == 33'd0, "fields set without alarm")
  `TSCD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:34] == 6'd0, "padding bits set")

endmodule

bind two_sided_cusum_detector_unit tscd_checker u_tscd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/two_sided_cusum_detector_unit_tb.sv
`timescale 1ns / 100ps

module two_sided_cusum_detector_unit_tb;
  import tscd_pkg::*;

  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 178;
  localparam int unsigned QuietPhase    = 2;
  localparam int unsigned HoldPhase     = 4;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned LongRunItems  = 40;
  localparam int unsigned StallLimit    = 3000;

  localparam longint SumHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumLo = -SumHi - 64'sd1;
  localparam logic [CfgDataW-1:0] ThrAllOnes = '1;

  typedef enum logic {RowWrite, RowSample} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgAddrW-1:0]  addr;
    logic [CfgDataW-1:0]  wdata;
    logic [SampleW-1:0]   smp;
    logic                 has_exp;
    result_t              exp_res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [15:0] sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] alarm, [1] direction, [17:2] alarm_index,
                                       // [33:18] change_index, rest 0

  // detector mirror: settings and state
  longint          cfg_mean;
  longint          cfg_half;
  longint          cfg_gain;
  longint          cfg_thr;
  longint          up_acc;
  longint          up_floor;
  logic [IdxW-1:0] up_floor_idx;
  longint          dn_acc;
  longint          dn_floor;
  logic [IdxW-1:0] dn_floor_idx;
  logic [IdxW-1:0] next_idx;

  result_t     pending_results[$];
  stim_row_t   plan_q[$];

  int unsigned err_cnt = 0;
  int unsigned n_samples = 0;
  int unsigned alarms_up = 0;
  int unsigned alarms_dn = 0;

  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;
  bit sink_hold_req = 1'b0;

  int seg_left   = 0;
  int seg_level  = 0;
  int seg_spread = 200;
  int seg_jitter = 40;

  two_sided_cusum_detector_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat48(longint v);
    if (v > SumHi) return SumHi;
    if (v < SumLo) return SumLo;
    return v;
  endfunction

  function automatic void restart_cusum();
    up_acc = 0;
    up_floor = 0;
    up_floor_idx = '0;
    dn_acc = 0;
    dn_floor = 0;
    dn_floor_idx = '0;
    next_idx = '0;
  endfunction

  function automatic result_t cusum_advance(logic [SampleW-1:0] smp);
    longint          dev;
    logic [IdxW-1:0] idx_now;
    logic [IdxW-1:0] idx_after;
    bit              up_over;
    bit              dn_over;
    result_t         res;
    dev = longint'($signed(smp)) - cfg_mean;
    idx_now = next_idx;
    idx_after = next_idx + 1'b1;
    up_acc = sat48(up_acc + (dev - cfg_half) * cfg_gain);
    dn_acc = sat48(dn_acc + (-dev - cfg_half) * cfg_gain);
    if (up_acc < up_floor) begin
      up_floor = up_acc;
      up_floor_idx = idx_after;
    end
    if (dn_acc < dn_floor) begin
      dn_floor = dn_acc;
      dn_floor_idx = idx_after;
    end
    up_over = (up_acc - up_floor) > cfg_thr;
    dn_over = (dn_acc - dn_floor) > cfg_thr;
    res = '0;
    if (up_over || dn_over) begin
      res.alarm = 1'b1;
      res.direction = !up_over;
      res.alarm_index = idx_now;
      res.change_index = up_over ? up_floor_idx : dn_floor_idx;
      restart_cusum();
    end else begin
      next_idx = idx_after;
    end
    return res;
  endfunction

  function automatic result_t make_result(bit alarm, bit dir, logic [IdxW-1:0] ai,
                                          logic [IdxW-1:0] ci);
    result_t r;
    r.alarm = alarm;
    r.direction = dir;
    r.alarm_index = ai;
    r.change_index = ci;
    return r;
  endfunction

  function automatic void add_cfg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = RowWrite;
    row.addr = addr;
    row.wdata = val;
    plan_q.push_back(row);
  endfunction

  function automatic void add_smp(logic [SampleW-1:0] smp);
    stim_row_t row;
    row = '0;
    row.kind = RowSample;
    row.smp = smp;
    plan_q.push_back(row);
  endfunction

  function automatic void add_smp_chk(logic [SampleW-1:0] smp, result_t res);
    stim_row_t row;
    row = '0;
    row.kind = RowSample;
    row.smp = smp;
    row.has_exp = 1'b1;
    row.exp_res = res;
    plan_q.push_back(row);
  endfunction

  function automatic logic [SampleW-1:0] next_random_sample();
    int v;
    if (seg_left == 0) begin
      seg_left = $urandom_range(3, 40);
      seg_level = int'(cfg_mean) + int'($urandom_range(0, 2 * seg_spread)) - seg_spread;
    end
    seg_left--;
    if ($urandom_range(99) < 8) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      v = seg_level + int'($urandom_range(0, 2 * seg_jitter)) - seg_jitter;
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[SampleW-1:0];
  endfunction

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      RegRefMean:   cfg_mean = longint'($signed(val[MeanW-1:0]));
      RegHalfMag:   cfg_half = longint'(val[HalfW-1:0]);
      RegGain:      cfg_gain = longint'(val[GainW-1:0]);
      RegThreshold: cfg_thr = longint'(val[ThrW-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [SampleW-1:0] smp, bit has_exp, result_t exp_res);
    result_t want;
    @(negedge clk_i);
    if (src_idle_en) begin
      while ($urandom_range(99) < 28) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = cusum_advance(smp);
    if (has_exp) want = exp_res;
    pending_results.push_back(want);
    n_samples++;
  endtask

  task automatic pick_config();
    int     mean_v;
    int     half_v;
    int     gain_v;
    longint thr_v;
    case ($urandom_range(0, 4))
      0: mean_v = -32768;
      1: mean_v = 32767;
      2: mean_v = int'($urandom_range(0, 65535)) - 32768;
      default: mean_v = int'($urandom_range(0, 2000)) - 1000;
    endcase
    case ($urandom_range(0, 5))
      0: half_v = 0;
      1: half_v = 32767;
      2: half_v = $urandom_range(0, 32767);
      default: half_v = $urandom_range(0, 600);
    endcase
    case ($urandom_range(0, 7))
      0: gain_v = 0;
      1: gain_v = 65535;
      2: gain_v = 256;
      3: gain_v = $urandom_range(0, 65535);
      default: gain_v = $urandom_range(1, 2048);
    endcase
    case ($urandom_range(0, 5))
      0: thr_v = 0;
      1: thr_v = SumHi;
      2: thr_v = longint'({$urandom, $urandom}) & SumHi;
      default: thr_v = longint'(gain_v) * longint'(half_v + 32) *
                       longint'($urandom_range(1, 30));
    endcase
    write_reg(RegRefMean, CfgDataW'(mean_v[MeanW-1:0]));
    write_reg(RegHalfMag, CfgDataW'(half_v[HalfW-1:0]));
    write_reg(RegGain, CfgDataW'(gain_v[GainW-1:0]));
    write_reg(RegThreshold, thr_v[CfgDataW-1:0]);
    seg_left = 0;
    seg_spread = 3 * half_v + 200;
    seg_jitter = half_v / 2 + 40;
  endtask

  task automatic check_result(logic [OutDataW-1:0] bus);
    result_t got;
    result_t want;
    got = bus[$bits(result_t)-1:0];
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing pending: tdata=%h", bus);
      err_cnt++;
    end else begin
      want = pending_results.pop_front();
      if (got.alarm !== want.alarm) begin
        $error("alarm: expected %0d, actual %0d", want.alarm, got.alarm);
        err_cnt++;
      end
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, actual %0d", want.direction, got.direction);
        err_cnt++;
      end
      if (got.alarm_index !== want.alarm_index) begin
        $error("alarm_index: expected %0d, actual %0d", want.alarm_index, got.alarm_index);
        err_cnt++;
      end
      if (got.change_index !== want.change_index) begin
        $error("change_index: expected %0d, actual %0d", want.change_index, got.change_index);
        err_cnt++;
      end
      if (bus[OutDataW-1:$bits(result_t)] !== '0) begin
        $error("tdata padding: expected 0, actual %h", bus[OutDataW-1:$bits(result_t)]);
        err_cnt++;
      end
    end
    if (got.alarm === 1'b1) begin
      if (got.direction === 1'b1) begin
        alarms_dn++;
      end else begin
        alarms_up++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end
      m_axis_tready <= !sink_idle_en || ($urandom_range(99) >= 28);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("two_sided_cusum_detector_unit test failed");
    $finish;
  end

  initial begin : main_seq
    stim_row_t row;
    cfg_we_i = 1'b0;
    cfg_addr_i = RegRefMean;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    cfg_mean = 0;
    cfg_half = 0;
    cfg_gain = longint'(GainReset);
    cfg_thr = 0;
    restart_cusum();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero threshold, any rise fires, minimum at the start
    add_smp_chk(0, make_result(1'b0, 1'b0, 0, 0));
    add_smp_chk(0, make_result(1'b0, 1'b0, 0, 0));
    add_smp_chk(1, make_result(1'b1, 1'b0, 2, 0));
    add_smp_chk(-1, make_result(1'b1, 1'b1, 0, 0));
    // both sides over threshold: upward wins
    add_cfg(RegThreshold, ThrAllOnes);
    add_smp(3);
    add_smp(-6);
    add_smp(3);
    add_cfg(RegThreshold, 511);
    add_smp_chk(0, make_result(1'b1, 1'b0, 3, 2));
    // equal minima keep the earlier index
    add_cfg(RegThreshold, ThrAllOnes);
    add_smp(-1);
    add_smp(1);
    add_smp(-1);
    add_cfg(RegThreshold, 0);
    add_smp_chk(1, make_result(1'b1, 1'b0, 3, 1));
    // register and sample extremes
    add_cfg(RegRefMean, 32767);
    add_cfg(RegHalfMag, 32767);
    add_cfg(RegGain, 65535);
    add_cfg(RegThreshold, ThrAllOnes);
    add_smp(16'h8000);
    add_smp(16'h7FFF);
    add_cfg(RegRefMean, 16'h8000);
    add_cfg(RegGain, 0);
    add_smp(16'h7FFF);
    add_smp(16'h8000);
    add_cfg(RegThreshold, 0);
    add_smp(0);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == RowWrite) begin
        write_reg(row.addr, row.wdata);
      end else begin
        send_sample(row.smp, row.has_exp, row.exp_res);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      src_idle_en = (ph != QuietPhase);
      sink_idle_en = (ph != QuietPhase);
      pick_config();
      if (ph == HoldPhase) sink_hold_req = 1'b1;
      repeat (ItemsPerPhase) send_sample(next_random_sample(), 1'b0, '0);
    end

    // long downward drift under a huge threshold, then a zero threshold fires
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(RegRefMean, 0);
    write_reg(RegHalfMag, 0);
    write_reg(RegGain, 65535);
    write_reg(RegThreshold, ThrAllOnes);
    repeat (LongRunItems) begin
      send_sample(16'h8000 + SampleW'($urandom_range(0, 768)), 1'b0, '0);
    end
    write_reg(RegThreshold, 0);
    send_sample(16'h7FFF, 1'b0, '0);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (16) send_sample(next_random_sample(), 1'b0, '0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d samples: directed cases, %0d random setups, a long drift run.",
             n_samples, NumPhases);
    $display("Alarms seen: %0d upward, %0d downward; %0d mismatches.",
             alarms_up, alarms_dn, err_cnt);
    if (err_cnt == 0) begin
      $display("two_sided_cusum_detector_unit test passed");
    end else begin
      $display("two_sided_cusum_detector_unit test failed");
    end
    $finish;
  end

endmodule

// File: two_sided_cusum_detector_unit.f
+incdir+design
design/tscd_pkg.sv
design/tscd_front.sv
design/tscd_fifo.sv
design/tscd_back.sv
design/two_sided_cusum_detector_unit.sv
design/tscd_checker.sv
dv/two_sided_cusum_detector_unit_tb.sv
